/* hdl/bilinear_table_interpolator_assert.svh */
// assertion macros for the bilinear table interpolator
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTI_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bti assertion failed");
`define BTI_ASSERT(label, prop) `BTI_ASSERT_CLK(label, i_clk, i_rst_n, prop)
`else
`define BTI_ASSERT_CLK(label, clk, rst_n, prop)
`define BTI_ASSERT(label, prop)
`endif
`endif

/* hdl/bti_pkg.sv */
// shared types and constants of the bilinear table interpolator
`timescale 1ns / 1ps
package bti_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int FRAC_W       = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [1:0] CFG_ROWS_USED     = 2'd0;
    localparam logic [1:0] CFG_COLS_USED     = 2'd1;
    localparam logic [1:0] CFG_INV_SPACING_X = 2'd2;
    localparam logic [1:0] CFG_INV_SPACING_Y = 2'd3;

    localparam logic [6:0]  ROWS_USED_RST   = 7'd64;
    localparam logic [6:0]  COLS_USED_RST   = 7'd64;
    localparam logic [23:0] INV_SPACING_RST = 24'd65536;

    typedef struct packed {
        logic              op;
        logic [31:0]       x_pos;
        logic [31:0]       y_pos;
        logic [5:0]        entry_row;
        logic [5:0]        entry_col;
        logic signed [31:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               outside;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_en;

    typedef struct packed {
        logic              is_eval;
        logic              outside;
        logic              row_odd;
        logic              col_odd;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } t_locate;

endpackage

/* hdl/bti_ifs.sv */
// valid/ready channel interfaces for input, result and configuration words
`timescale 1ns / 1ps
interface bti_in_if;
    import bti_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bti_out_if;
    import bti_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bti_cfg_if;
    import bti_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/bti_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module bti_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                            i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                            o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/bti_locate.sv */
// coordinate scaling, corner location and bank addressing (stages 1 and 2)
`timescale 1ns / 1ps
module bti_locate #(
    parameter int MAX_SIDE = bti_pkg::MAX_SIDE_DEF
) (
    input  logic                 i_clk,
    input  bti_pkg::t_stage_en   i_en,
    input  logic                 i_v1,
    input  bti_pkg::t_in_word    i_word,
    input  logic [6:0]           i_rows_used,
    input  logic [6:0]           i_cols_used,
    input  logic [23:0]          i_inv_x,
    input  logic [23:0]          i_inv_y,
    output logic [3:0][2*(($clog2(MAX_SIDE) > 1) ? $clog2(MAX_SIDE) - 1 : 1)-1:0] o_rd_addr,
    output logic [3:0]           o_we,
    output logic [2*(($clog2(MAX_SIDE) > 1) ? $clog2(MAX_SIDE) - 1 : 1)-1:0] o_wr_addr,
    output logic [31:0]          o_wr_data,
    output bti_pkg::t_locate     o_loc
);
    import bti_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int HALF_W = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int CNT_W  = 9;

    logic              r_op;
    logic [55:0]       r_px;
    logic [55:0]       r_py;
    logic [5:0]        r_row;
    logic [5:0]        r_col;
    logic [31:0]       r_val;
    t_locate           r_loc;

    logic [23:0]       w_ix;
    logic [23:0]       w_iy;
    logic [CNT_W-1:0]  w_nr;
    logic [CNT_W-1:0]  w_nc;
    logic              w_outside;
    logic [IDX_W-1:0]  w_lr;
    logic [IDX_W-1:0]  w_ur;
    logic [IDX_W-1:0]  w_lc;
    logic [IDX_W-1:0]  w_uc;
    logic              w_in_range;
    logic [IDX_W-1:0]  w_wrow;
    logic [IDX_W-1:0]  w_wcol;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_op  <= i_word.op;
            r_px  <= 56'(i_word.x_pos) * 56'(i_inv_x);
            r_py  <= 56'(i_word.y_pos) * 56'(i_inv_y);
            r_row <= i_word.entry_row;
            r_col <= i_word.entry_col;
            r_val <= i_word.entry_value;
        end
    end

    assign w_ix = r_px[55:32];
    assign w_iy = r_py[55:32];
    assign w_nr = ({2'b0, i_rows_used} > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                            : {2'b0, i_rows_used};
    assign w_nc = ({2'b0, i_cols_used} > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                            : {2'b0, i_cols_used};
    assign w_outside = ((25'(w_ix) + 25'd1) >= 25'(w_nr)) ||
                       ((25'(w_iy) + 25'd1) >= 25'(w_nc));

    assign w_lr = w_ix[IDX_W-1:0];
    assign w_lc = w_iy[IDX_W-1:0];
    assign w_ur = w_lr + IDX_W'(1);
    assign w_uc = w_lc + IDX_W'(1);

    // each parity bank holds exactly one of the four corners
    always_comb begin
        logic [IDX_W-1:0] rsel;
        logic [IDX_W-1:0] csel;
        logic [IDX_W-1:0] rhalf;
        logic [IDX_W-1:0] chalf;
        for (int b = 0; b < 4; b++) begin
            rsel = (w_lr[0] == b[1]) ? w_lr : w_ur;
            csel = (w_lc[0] == b[0]) ? w_lc : w_uc;
            rhalf = rsel >> 1;
            chalf = csel >> 1;
            o_rd_addr[b] = {HALF_W'(rhalf), HALF_W'(chalf)};
        end
    end

    assign w_in_range = ({3'b0, r_row} < CNT_W'(MAX_SIDE)) &&
                        ({3'b0, r_col} < CNT_W'(MAX_SIDE));
    assign w_wrow = IDX_W'(r_row);
    assign w_wcol = IDX_W'(r_col);
    assign o_wr_addr = {HALF_W'(w_wrow >> 1), HALF_W'(w_wcol >> 1)};
    assign o_wr_data = r_val;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            o_we[b] = i_en.s2 && i_v1 && (r_op == OP_WRITE) && w_in_range &&
                      (2'(b) == {r_row[0], r_col[0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_loc.is_eval <= (r_op == OP_EVAL);
            r_loc.outside <= w_outside;
            r_loc.row_odd <= w_lr[0];
            r_loc.col_odd <= w_lc[0];
            r_loc.fx      <= r_px[31:16];
            r_loc.fy      <= r_py[31:16];
        end
    end

    assign o_loc = r_loc;
endmodule

/* hdl/bti_store.sv */
// sample table split into four row/column parity banks, corner routing
`timescale 1ns / 1ps
module bti_store #(
    parameter int MAX_SIDE = bti_pkg::MAX_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_re,
    input  logic [3:0][2*(($clog2(MAX_SIDE) > 1) ? $clog2(MAX_SIDE) - 1 : 1)-1:0] i_rd_addr,
    input  logic [3:0]         i_we,
    input  logic [2*(($clog2(MAX_SIDE) > 1) ? $clog2(MAX_SIDE) - 1 : 1)-1:0] i_wr_addr,
    input  logic [31:0]        i_wr_data,
    input  logic               i_row_odd,
    input  logic               i_col_odd,
    output logic signed [31:0] o_f00,
    output logic signed [31:0] o_f01,
    output logic signed [31:0] o_f10,
    output logic signed [31:0] o_f11
);
    localparam int IDX_W   = $clog2(MAX_SIDE);
    localparam int HALF_W  = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BANK_AW = 2 * HALF_W;

    logic [3:0][31:0] w_rd_data;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bti_ram #(
            .W     (32),
            .DEPTH (1 << BANK_AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_we[b]),
            .i_waddr (i_wr_addr),
            .i_wdata (i_wr_data),
            .i_re    (i_re),
            .i_raddr (i_rd_addr[b]),
            .o_rdata (w_rd_data[b])
        );
    end

    assign o_f00 = $signed(w_rd_data[{i_row_odd, i_col_odd}]);
    assign o_f01 = $signed(w_rd_data[{i_row_odd, !i_col_odd}]);
    assign o_f10 = $signed(w_rd_data[{!i_row_odd, i_col_odd}]);
    assign o_f11 = $signed(w_rd_data[{!i_row_odd, !i_col_odd}]);
endmodule

/* hdl/bti_blend.sv */
// weighted blend of the four corners (stages 3 to 6, stage 6 is the output register)
`timescale 1ns / 1ps
module bti_blend (
    input  logic               i_clk,
    input  bti_pkg::t_stage_en i_en,
    input  bti_pkg::t_locate   i_loc,
    input  logic signed [31:0] i_f00,
    input  logic signed [31:0] i_f01,
    input  logic signed [31:0] i_f10,
    input  logic signed [31:0] i_f11,
    output bti_pkg::t_out_word o_word
);
    import bti_pkg::*;

    logic signed [49:0] r_p00;
    logic signed [49:0] r_p01;
    logic signed [49:0] r_p10;
    logic signed [49:0] r_p11;
    logic [FRAC_W-1:0]  r_fx3;
    logic               r_out3;
    logic signed [49:0] r_a0;
    logic signed [49:0] r_a1;
    logic [FRAC_W-1:0]  r_fx4;
    logic               r_out4;
    logic signed [67:0] r_q0;
    logic signed [67:0] r_q1;
    logic               r_out5;
    t_out_word          r_word;

    logic [FRAC_W:0]    w_wy0;
    logic [FRAC_W:0]    w_wy1;
    logic [FRAC_W:0]    w_wx0;
    logic [FRAC_W:0]    w_wx1;
    logic signed [67:0] n_sum;

    assign w_wy1 = {1'b0, i_loc.fy};
    assign w_wy0 = (FRAC_W + 1)'(1 << FRAC_W) - w_wy1;
    assign w_wx1 = {1'b0, r_fx4};
    assign w_wx0 = (FRAC_W + 1)'(1 << FRAC_W) - w_wx1;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_p00  <= i_f00 * $signed({1'b0, w_wy0});
            r_p01  <= i_f01 * $signed({1'b0, w_wy1});
            r_p10  <= i_f10 * $signed({1'b0, w_wy0});
            r_p11  <= i_f11 * $signed({1'b0, w_wy1});
            r_fx3  <= i_loc.fx;
            r_out3 <= i_loc.outside;
        end
        if (i_en.s4) begin
            r_a0   <= r_p00 + r_p01;
            r_a1   <= r_p10 + r_p11;
            r_fx4  <= r_fx3;
            r_out4 <= r_out3;
        end
        if (i_en.s5) begin
            r_q0   <= r_a0 * $signed({1'b0, w_wx0});
            r_q1   <= r_a1 * $signed({1'b0, w_wx1});
            r_out5 <= r_out4;
        end
        if (i_en.s6) begin
            r_word.interp_value <= r_out5 ? 32'sd0 : $signed(n_sum[63:32]);
            r_word.outside      <= r_out5;
        end
    end

    // floor from q36.32 to the entries' own scale is the plain drop of the low 32 bits
    assign n_sum = r_q0 + r_q1;

    assign o_word = r_word;
endmodule

/* hdl/bilinear_table_interpolator.sv */
// An evaluate word goes through locate, store and blend to a result; a write gives none.
// Throughput: one word per cycle, writes and evaluates alike, unless o_out stalls it.
// The table sits in four row/column parity banks, so all four corners read in parallel.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the config registers.
// Table contents are not cleared by reset and are undefined until written.
`timescale 1ns / 1ps
`include "bilinear_table_interpolator_assert.svh"
module bilinear_table_interpolator #(
    parameter int MAX_SIDE = bti_pkg::MAX_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bti_in_if.sink    i_in,
    bti_cfg_if.sink   i_cfg,
    bti_out_if.source o_out
);
    import bti_pkg::*;

    localparam int IDX_W   = $clog2(MAX_SIDE);
    localparam int HALF_W  = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BANK_AW = 2 * HALF_W;

    logic [6:0]  r_rows_used;
    logic [6:0]  r_cols_used;
    logic [23:0] r_inv_x;
    logic [23:0] r_inv_y;
    logic [6:1]  r_v;
    logic [6:1]  n_v;
    logic [7:1]  w_en;
    t_stage_en   w_sen;

    logic [3:0][BANK_AW-1:0] w_rd_addr;
    logic [3:0]              w_we;
    logic [BANK_AW-1:0]      w_wr_addr;
    logic [31:0]             w_wr_data;
    t_locate                 w_loc;
    logic signed [31:0]      w_f00;
    logic signed [31:0]      w_f01;
    logic signed [31:0]      w_f10;
    logic signed [31:0]      w_f11;
    t_out_word               w_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= ROWS_USED_RST;
            r_cols_used <= COLS_USED_RST;
            r_inv_x     <= INV_SPACING_RST;
            r_inv_y     <= INV_SPACING_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_ROWS_USED:     r_rows_used <= i_cfg.data.value[6:0];
                CFG_COLS_USED:     r_cols_used <= i_cfg.data.value[6:0];
                CFG_INV_SPACING_X: r_inv_x     <= i_cfg.data.value;
                CFG_INV_SPACING_Y: r_inv_y     <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[7] = o_out.ready;
        for (int k = 6; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_sen.s1 = w_en[1];
    assign w_sen.s2 = w_en[2];
    assign w_sen.s3 = w_en[3];
    assign w_sen.s4 = w_en[4];
    assign w_sen.s5 = w_en[5];
    assign w_sen.s6 = w_en[6];

    always_comb begin
        n_v[1] = w_en[1] ? i_in.valid : r_v[1];
        n_v[2] = w_en[2] ? r_v[1] : r_v[2];
        n_v[3] = w_en[3] ? (r_v[2] && w_loc.is_eval) : r_v[3];
        n_v[4] = w_en[4] ? r_v[3] : r_v[4];
        n_v[5] = w_en[5] ? r_v[4] : r_v[5];
        n_v[6] = w_en[6] ? r_v[5] : r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_in.ready = w_en[1];

    bti_locate #(
        .MAX_SIDE (MAX_SIDE)
    ) u_locate (
        .i_clk       (i_clk),
        .i_en        (w_sen),
        .i_v1        (r_v[1]),
        .i_word      (i_in.data),
        .i_rows_used (r_rows_used),
        .i_cols_used (r_cols_used),
        .i_inv_x     (r_inv_x),
        .i_inv_y     (r_inv_y),
        .o_rd_addr   (w_rd_addr),
        .o_we        (w_we),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_loc       (w_loc)
    );

    bti_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .i_clk     (i_clk),
        .i_re      (w_en[2]),
        .i_rd_addr (w_rd_addr),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_row_odd (w_loc.row_odd),
        .i_col_odd (w_loc.col_odd),
        .o_f00     (w_f00),
        .o_f01     (w_f01),
        .o_f10     (w_f10),
        .o_f11     (w_f11)
    );

    bti_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (w_sen),
        .i_loc  (w_loc),
        .i_f00  (w_f00),
        .i_f01  (w_f01),
        .i_f10  (w_f10),
        .i_f11  (w_f11),
        .o_word (w_result)
    );

    assign o_out.valid = r_v[6];
    assign o_out.data  = w_result;

    `BTI_ASSERT(a_outside_zero, o_out.valid && o_out.data.outside |-> o_out.data.interp_value == 32'sd0)
    `BTI_ASSERT(a_stall_only_full, !i_in.ready |-> (&r_v))
    `BTI_ASSERT_CLK(a_write_no_result, i_clk, i_rst_n, r_v[2] && !w_loc.is_eval && w_en[3] |=> !r_v[3])
endmodule
